@@ rtl/lgrs_pkg.sv @@
// shared types and constants for the life generation row stream block
package lgrs_pkg;

	localparam int DATA_W     = 64;
	localparam int AW_W       = 7;
	localparam logic [AW_W-1:0] AW_RESET = 7'd64;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// one column's view of the three rows, already masked
	typedef struct packed {
		logic above;
		logic middle;
		logic row;
	} nbr_t;

	// per-word controls broadcast to every cell
	typedef struct packed {
		logic accept;
		logic first;
		logic last;
	} cell_ctl_t;

	typedef struct packed {
		logic [DATA_W-1:0] bits;
		logic              frame_end;
	} out_word_t;

endpackage

@@ rtl/lgrs_cell.sv @@
// one column cell: holds two row bits and computes the next state of its column
module lgrs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lgrs_pkg::cell_ctl_t ctl,
	input  logic              col_en,
	input  logic              row_bit,
	input  lgrs_pkg::nbr_t    left,
	input  lgrs_pkg::nbr_t    right,
	output lgrs_pkg::nbr_t    own,
	output logic              res_main,
	output logic              res_flush
);
	import lgrs_pkg::*;

	logic above_q;
	logic middle_q;
	logic [3:0] n_main;
	logic [3:0] n_flush;
	logic alive_main;

	function automatic logic life_rule(input logic alive, input logic [3:0] n);
		life_rule = (n == 4'd3) || (alive && (n == 4'd2));
	endfunction

	assign own.above  = above_q & col_en;
	assign own.middle = middle_q & col_en;
	assign own.row    = row_bit & col_en;

	// top row of a one-row frame sees dead rows above and below
	always_comb begin
		if (ctl.first) begin
			n_main     = 4'(left.row) + 4'(right.row);
			alive_main = own.row;
		end else begin
			n_main = 4'(left.above) + 4'(own.above) + 4'(right.above)
				+ 4'(left.middle) + 4'(right.middle)
				+ 4'(left.row) + 4'(own.row) + 4'(right.row);
			alive_main = own.middle;
		end
	end

	// bottom row flush: the row below is dead
	assign n_flush = 4'(left.middle) + 4'(own.middle) + 4'(right.middle)
		+ 4'(left.row) + 4'(right.row);

	assign res_main  = life_rule(alive_main, n_main) & col_en;
	assign res_flush = life_rule(own.row, n_flush) & col_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctl.accept) begin
			if (ctl.last) begin
				above_q  <= 1'b0;
				middle_q <= 1'b0;
			end else begin
				above_q  <= middle_q;
				middle_q <= own.row;
			end
		end
	end

endmodule

@@ rtl/lgrs_out_fifo.sv @@
// small output queue taking up to two words per cycle
module lgrs_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_a,
	input  lgrs_pkg::out_word_t word_a,
	input  logic                push_b,
	input  lgrs_pkg::out_word_t word_b,
	input  logic                pop,
	output lgrs_pkg::out_word_t head,
	output logic                not_empty,
	output logic                room_two
);
	import lgrs_pkg::*;

	out_word_t mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [FIFO_CNT_W-1:0] n_push;

	assign n_push    = FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b);
	assign head      = mem[rd_q];
	assign not_empty = (count_q != '0);
	assign room_two  = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_a)
			mem[wr_q] <= word_a;
		if (push_b)
			mem[wr_q + FIFO_PTR_W'(1)] <= word_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_PTR_W'(n_push);
			if (pop)
				rd_q <= rd_q + FIFO_PTR_W'(1);
			count_q <= count_q + n_push - FIFO_CNT_W'(pop);
		end
	end

endmodule

@@ rtl/life_generation_row_stream_top.sv @@
// life generation over a row stream: a row of column cells and an output queue
// a result word enters the output queue when the row word that causes it is accepted
// throughput: one row word per cycle while s_tready is high; the bottom row of a frame yields two words,
//   and the output drains one word per cycle while m_tready is high, through a four-entry queue
// s_tready drops while fewer than two queue entries are free
// reset clears held rows and the queue; active_width returns to 64
module life_generation_row_stream_top #(
	parameter int ROW_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lgrs_pkg::AW_W-1:0]  cfg_data,   // active_width
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lgrs_pkg::DATA_W-1:0] s_tdata,   // row_bits
	input  logic                       s_tlast,    // last_row
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lgrs_pkg::DATA_W-1:0] m_tdata,   // next_row_bits
	output logic                       m_tlast     // frame_end
);
	import lgrs_pkg::*;

	typedef enum logic [1:0] {HELD_NONE, HELD_ONE, HELD_TWO} held_t;

	held_t            rows_held_q;
	logic [AW_W-1:0]  active_width_q;
	logic             s_accept;
	cell_ctl_t        ctl;
	nbr_t             nbr [ROW_WIDTH];
	logic [DATA_W-1:0] res_main;
	logic [DATA_W-1:0] res_flush;
	out_word_t        word_a;
	out_word_t        word_b;
	out_word_t        head;
	logic             push_a;
	logic             push_b;
	logic             room_two;

	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;

	assign ctl.accept = s_accept;
	assign ctl.first  = (rows_held_q == HELD_NONE);
	assign ctl.last   = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= AW_RESET;
			rows_held_q    <= HELD_NONE;
		end else begin
			if (cfg_valid && cfg_ready)
				active_width_q <= cfg_data;
			if (s_accept) begin
				if (s_tlast)
					rows_held_q <= HELD_NONE;
				else if (ctl.first)
					rows_held_q <= HELD_ONE;
				else
					rows_held_q <= HELD_TWO;
			end
		end
	end

	for (genvar x = 0; x < ROW_WIDTH; x++) begin : g_col
		nbr_t left;
		nbr_t right;
		logic col_en;

		assign col_en = (AW_W'(x) < active_width_q);

		if (x == 0) begin : g_l_edge
			assign left = '0;
		end else begin : g_l_in
			assign left = nbr[x-1];
		end

		if (x == ROW_WIDTH - 1) begin : g_r_edge
			assign right = '0;
		end else begin : g_r_in
			assign right = nbr[x+1];
		end

		lgrs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.col_en    (col_en),
			.row_bit   (s_tdata[x]),
			.left      (left),
			.right     (right),
			.own       (nbr[x]),
			.res_main  (res_main[x]),
			.res_flush (res_flush[x])
		);
	end

	if (ROW_WIDTH < DATA_W) begin : g_pad
		assign res_main[DATA_W-1:ROW_WIDTH]  = '0;
		assign res_flush[DATA_W-1:ROW_WIDTH] = '0;
	end

	// a top row only yields a word when it is also the bottom row
	assign push_a           = s_accept && (!ctl.first || s_tlast);
	assign push_b           = s_accept && !ctl.first && s_tlast;
	assign word_a.bits      = res_main;
	assign word_a.frame_end = ctl.first;
	assign word_b.bits      = res_flush;
	assign word_b.frame_end = 1'b1;

	lgrs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.word_a    (word_a),
		.push_b    (push_b),
		.word_b    (word_b),
		.pop       (m_tvalid && m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.room_two  (room_two)
	);

	assign s_tready = room_two;
	assign m_tdata  = head.bits;
	assign m_tlast  = head.frame_end;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tlast |=> rows_held_q == HELD_NONE)
		else $error("bottom row did not end the frame");

	a_row_held: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && !s_tlast |=> rows_held_q != HELD_NONE)
		else $error("row word not held");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_accept))
		else $error("queue filled without an accepted word");

endmodule
